[hdl/zif_pkg.sv]
// ----------------------------------------------------------------------------
// zif_pkg: shared types and constants of the zone influence falloff core
// Widths of the fixed point datapath, register indexes, config bundle.
// ----------------------------------------------------------------------------
package zif_pkg;

	localparam int CoordW   = 24;  // input coordinate, signed, 8 fraction bits
	localparam int MagW     = 24;  // |point - centre|
	localparam int RadW     = 21;  // sphere radius and blend distance
	localparam int ExtW     = 23;  // box half extent
	localparam int SqW      = 2 * MagW;
	localparam int SumW     = SqW + 2;
	localparam int RootW    = SumW / 2;
	localparam int RemW     = SumW + 1;
	localparam int FracBits = 16;
	localparam int InflW    = FracBits + 1;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 23;

	localparam logic [InflW-1:0] FullScale = InflW'(1) << FracBits;

	localparam logic [CfgIdxW-1:0] RegEnable = 3'd0;
	localparam logic [CfgIdxW-1:0] RegShape  = 3'd1;
	localparam logic [CfgIdxW-1:0] RegRadius = 3'd2;
	localparam logic [CfgIdxW-1:0] RegExtX   = 3'd3;
	localparam logic [CfgIdxW-1:0] RegExtY   = 3'd4;
	localparam logic [CfgIdxW-1:0] RegExtZ   = 3'd5;
	localparam logic [CfgIdxW-1:0] RegBlend  = 3'd6;

	localparam logic ShapeSphere = 1'b0;
	localparam logic ShapeBox    = 1'b1;

	typedef struct packed {
		logic            enabled;
		logic            shape;
		logic [RadW-1:0] radius;
		logic [ExtW-1:0] ext_x;
		logic [ExtW-1:0] ext_y;
		logic [ExtW-1:0] ext_z;
		logic [RadW-1:0] blend;
	} zif_cfg_t;

	// result selection that travels through the divider
	typedef struct packed {
		logic zero;
		logic full;
	} zif_flags_t;

endpackage

[hdl/zone_influence_falloff_core.sv]
// ----------------------------------------------------------------------------
// zone_influence_falloff_core: zone weight at a query point
// Sphere or box outside distance, square root and linear falloff, pipelined.
// ----------------------------------------------------------------------------
// Pipeline order: geometry, square root, falloff select register, divide,
//   output register.
// Throughput: one request per cycle; the whole pipe moves on one enable,
//   set by the output register being empty or being taken.
// Reset: all valid bits clear, config registers return to their defaults.
module zone_influence_falloff_core import zif_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [CoordW-1:0]   point_x,
	input  logic signed [CoordW-1:0]   point_y,
	input  logic signed [CoordW-1:0]   point_z,
	input  logic signed [CoordW-1:0]   centre_x,
	input  logic signed [CoordW-1:0]   centre_y,
	input  logic signed [CoordW-1:0]   centre_z,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [InflW-1:0]           influence,
	input  logic                       cfg_we,
	input  logic [CfgIdxW-1:0]         cfg_index,
	input  logic [CfgDataW-1:0]        cfg_data
);

	zif_cfg_t         cfg_q;
	logic             adv;
	logic             geo_vld, sq_vld, v_s30;
	logic [SumW-1:0]  sum;
	logic [RootW-1:0] root;
	logic [RootW-1:0] outside;
	zif_flags_t       fl, fl_s30;
	logic [RadW-1:0]  num_s30;

	// Config registers. Writes are expected only while the pipe is empty;
	// stages read the live registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled <= 1'b1;
			cfg_q.shape   <= ShapeSphere;
			cfg_q.radius  <= RadW'(12800);
			cfg_q.ext_x   <= ExtW'(12800);
			cfg_q.ext_y   <= ExtW'(12800);
			cfg_q.ext_z   <= ExtW'(12800);
			cfg_q.blend   <= RadW'(2560);
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegEnable: cfg_q.enabled <= cfg_data[0];
				RegShape:  cfg_q.shape   <= cfg_data[0];
				RegRadius: cfg_q.radius  <= cfg_data[RadW-1:0];
				RegExtX:   cfg_q.ext_x   <= cfg_data[ExtW-1:0];
				RegExtY:   cfg_q.ext_y   <= cfg_data[ExtW-1:0];
				RegExtZ:   cfg_q.ext_z   <= cfg_data[ExtW-1:0];
				RegBlend:  cfg_q.blend   <= cfg_data[RadW-1:0];
				default: ;  // unknown index: dropped
			endcase
		end
	end

	// Global pipe enable: output slot free or being drained.
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	zif_geom u_geom (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.cfg     (cfg_q),
		.vld_in  (in_valid),
		.px      (point_x),
		.py      (point_y),
		.pz      (point_z),
		.cx      (centre_x),
		.cy      (centre_y),
		.cz      (centre_z),
		.vld_out (geo_vld),
		.sum_out (sum)
	);

	zif_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld_in  (geo_vld),
		.x       (sum),
		.vld_out (sq_vld),
		.root    (root)
	);

	// Falloff select. Sphere subtracts the radius after the root; the box
	// overshoot was taken before squaring. Anything at or past a nonzero blend
	// width is zero, so only quotients of num < blend reach the output.
	always_comb begin
		if (cfg_q.shape == ShapeBox) begin
			outside = root;
		end else begin
			outside = (root > RootW'(cfg_q.radius)) ? root - RootW'(cfg_q.radius) : '0;
		end
		fl.full = cfg_q.enabled && (cfg_q.blend == '0) && (outside == '0);
		fl.zero = !cfg_q.enabled ||
			((cfg_q.blend == '0) ? (outside != '0) : (outside >= RootW'(cfg_q.blend)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s30 <= 1'b0;
		end else if (adv) begin
			v_s30 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fl_s30  <= fl;
			num_s30 <= outside[RadW-1:0];
		end
	end

	zif_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.blend     (cfg_q.blend),
		.vld_in    (v_s30),
		.flags_in  (fl_s30),
		.num       (num_s30),
		.vld_out   (out_valid),
		.influence (influence)
	);

	// Checks
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> influence <= FullScale)
		else $error("influence above full scale");

	a_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !cfg_q.enabled) |-> influence == '0)
		else $error("disabled zone gave nonzero influence");

	a_hard: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && cfg_q.blend == '0) |-> (influence == '0 || influence == FullScale))
		else $error("hard edge gave partial influence");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(influence)))
		else $error("stalled result changed");

endmodule

[hdl/zif_geom.sv]
// ----------------------------------------------------------------------------
// zif_geom: per-axis distance, box overshoot, squares and their sum
// Four register stages: abs diff, overshoot, square, sum.
// ----------------------------------------------------------------------------
module zif_geom import zif_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  zif_cfg_t                 cfg,
	input  logic                     vld_in,
	input  logic signed [CoordW-1:0] px,
	input  logic signed [CoordW-1:0] py,
	input  logic signed [CoordW-1:0] pz,
	input  logic signed [CoordW-1:0] cx,
	input  logic signed [CoordW-1:0] cy,
	input  logic signed [CoordW-1:0] cz,
	output logic                     vld_out,
	output logic [SumW-1:0]          sum_out
);

	logic              v_s1, v_s2, v_s3, v_s4;
	logic [MagW-1:0]   ax_s1, ay_s1, az_s1;
	logic [MagW-1:0]   ox_s2, oy_s2, oz_s2;
	logic [SqW-1:0]    sx_s3, sy_s3, sz_s3;
	logic [SumW-1:0]   sum_s4;
	logic [MagW-1:0]   ax, ay, az, ox, oy, oz;

	function automatic logic [MagW-1:0] absdiff(input logic signed [CoordW-1:0] a,
			input logic signed [CoordW-1:0] b);
		logic signed [CoordW:0] d;
		logic [CoordW:0]        m;
		d = CoordW'(0) + {a[CoordW-1], a} - {b[CoordW-1], b};
		m = d[CoordW] ? -d : d;
		return m[MagW-1:0];
	endfunction

	function automatic logic [MagW-1:0] over(input logic [MagW-1:0] a,
			input logic [ExtW-1:0] he, input logic box);
		logic [MagW-1:0] h;
		h = {{(MagW-ExtW){1'b0}}, he};
		if (!box) begin
			return a;
		end
		return (a > h) ? a - h : '0;
	endfunction

	always_comb begin
		ax = absdiff(px, cx);
		ay = absdiff(py, cy);
		az = absdiff(pz, cz);
		ox = over(ax_s1, cfg.ext_x, cfg.shape == ShapeBox);
		oy = over(ay_s1, cfg.ext_y, cfg.shape == ShapeBox);
		oz = over(az_s1, cfg.ext_z, cfg.shape == ShapeBox);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vld_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1  <= ax;
			ay_s1  <= ay;
			az_s1  <= az;
			ox_s2  <= ox;
			oy_s2  <= oy;
			oz_s2  <= oz;
			sx_s3  <= ox_s2 * ox_s2;
			sy_s3  <= oy_s2 * oy_s2;
			sz_s3  <= oz_s2 * oz_s2;
			sum_s4 <= SumW'(sx_s3) + SumW'(sy_s3) + SumW'(sz_s3);
		end
	end

	assign vld_out = v_s4;
	assign sum_out = sum_s4;

endmodule

[hdl/zif_sqrt.sv]
// ----------------------------------------------------------------------------
// zif_sqrt: pipelined truncating integer square root
// One result bit per stage, most significant first.
// ----------------------------------------------------------------------------
module zif_sqrt import zif_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             vld_in,
	input  logic [SumW-1:0]  x,
	output logic             vld_out,
	output logic [RootW-1:0] root
);

	logic [RemW-1:0]  rem_s  [RootW];
	logic [RootW-1:0] root_s [RootW];
	logic             v_s    [RootW];

	for (genvar g = 0; g < RootW; g++) begin : g_stage
		localparam int Sh = RootW - 1 - g;
		logic [RemW-1:0]  rem_in, trial;
		logic [RootW-1:0] root_in;
		logic             v_in;

		if (g == 0) begin : g_first
			assign rem_in  = RemW'(x);
			assign root_in = '0;
			assign v_in    = vld_in;
		end else begin : g_next
			assign rem_in  = rem_s[g-1];
			assign root_in = root_s[g-1];
			assign v_in    = v_s[g-1];
		end

		// (root + 2^Sh)^2 - root^2 = root*2^(Sh+1) + 2^(2*Sh)
		assign trial = (RemW'(root_in) << (Sh + 1)) + (RemW'(1) << (2 * Sh));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (adv) begin
				v_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (rem_in >= trial) begin
					rem_s[g]  <= rem_in - trial;
					root_s[g] <= root_in | (RootW'(1) << Sh);
				end else begin
					rem_s[g]  <= rem_in;
					root_s[g] <= root_in;
				end
			end
		end
	end

	assign vld_out = v_s[RootW-1];
	assign root    = root_s[RootW-1];

endmodule

[hdl/zif_div.sv]
// ----------------------------------------------------------------------------
// zif_div: pipelined fraction divider and output register
// Restoring division, one quotient bit per stage, numerator below divisor.
// ----------------------------------------------------------------------------
module zif_div import zif_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic [RadW-1:0]  blend,
	input  logic             vld_in,
	input  zif_flags_t       flags_in,
	input  logic [RadW-1:0]  num,
	output logic             vld_out,
	output logic [InflW-1:0] influence
);

	logic [RadW-1:0]     rem_s   [FracBits];
	logic [FracBits-1:0] quo_s   [FracBits];
	zif_flags_t          flags_s [FracBits];
	logic                v_s     [FracBits];
	logic                v_q;
	logic [InflW-1:0]    infl_q;

	for (genvar g = 0; g < FracBits; g++) begin : g_stage
		logic [RadW-1:0]     rem_in;
		logic [FracBits-1:0] quo_in;
		zif_flags_t          fl_in;
		logic                v_in;
		logic [RadW:0]       r2;

		if (g == 0) begin : g_first
			assign rem_in = num;
			assign quo_in = '0;
			assign fl_in  = flags_in;
			assign v_in   = vld_in;
		end else begin : g_next
			assign rem_in = rem_s[g-1];
			assign quo_in = quo_s[g-1];
			assign fl_in  = flags_s[g-1];
			assign v_in   = v_s[g-1];
		end

		assign r2 = {rem_in, 1'b0};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (adv) begin
				v_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				flags_s[g] <= fl_in;
				if (r2 >= {1'b0, blend}) begin
					rem_s[g] <= RadW'(r2 - {1'b0, blend});
					quo_s[g] <= {quo_in[FracBits-2:0], 1'b1};
				end else begin
					rem_s[g] <= r2[RadW-1:0];
					quo_s[g] <= {quo_in[FracBits-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (adv) begin
			v_q <= v_s[FracBits-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (flags_s[FracBits-1].zero) begin
				infl_q <= '0;
			end else if (flags_s[FracBits-1].full) begin
				infl_q <= FullScale;
			end else begin
				infl_q <= FullScale - InflW'(quo_s[FracBits-1]);
			end
		end
	end

	assign vld_out   = v_q;
	assign influence = infl_q;

endmodule
